### rtl/md2_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the substitution table of the MD2 digest unit.
// Used by md2_ctrl, md2_datapath and md2_message_digest_unit; depends on nothing.
package md2_pkg;

  localparam int BLK_BYTES  = 16;   // bytes in one message block
  localparam int WORK_BYTES = 48;   // bytes in the mixing array
  localparam int ROUNDS     = 18;   // mixing rounds per block

  localparam int FILL_W  = $clog2(BLK_BYTES);
  localparam int PAD_W   = $clog2(BLK_BYTES) + 1;
  localparam int STEP_W  = $clog2(WORK_BYTES);
  localparam int ROUND_W = $clog2(ROUNDS);

  localparam logic [STEP_W-1:0]  STEP_LAST  = STEP_W'(WORK_BYTES - 1);
  localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);
  localparam logic [FILL_W-1:0]  BYTE_LAST  = FILL_W'(BLK_BYTES - 1);

  localparam logic [7:0] SBOX [256] = '{
    8'h29, 8'h2E, 8'h43, 8'hC9, 8'hA2, 8'hD8, 8'h7C, 8'h01,
    8'h3D, 8'h36, 8'h54, 8'hA1, 8'hEC, 8'hF0, 8'h06, 8'h13,
    8'h62, 8'hA7, 8'h05, 8'hF3, 8'hC0, 8'hC7, 8'h73, 8'h8C,
    8'h98, 8'h93, 8'h2B, 8'hD9, 8'hBC, 8'h4C, 8'h82, 8'hCA,
    8'h1E, 8'h9B, 8'h57, 8'h3C, 8'hFD, 8'hD4, 8'hE0, 8'h16,
    8'h67, 8'h42, 8'h6F, 8'h18, 8'h8A, 8'h17, 8'hE5, 8'h12,
    8'hBE, 8'h4E, 8'hC4, 8'hD6, 8'hDA, 8'h9E, 8'hDE, 8'h49,
    8'hA0, 8'hFB, 8'hF5, 8'h8E, 8'hBB, 8'h2F, 8'hEE, 8'h7A,
    8'hA9, 8'h68, 8'h79, 8'h91, 8'h15, 8'hB2, 8'h07, 8'h3F,
    8'h94, 8'hC2, 8'h10, 8'h89, 8'h0B, 8'h22, 8'h5F, 8'h21,
    8'h80, 8'h7F, 8'h5D, 8'h9A, 8'h5A, 8'h90, 8'h32, 8'h27,
    8'h35, 8'h3E, 8'hCC, 8'hE7, 8'hBF, 8'hF7, 8'h97, 8'h03,
    8'hFF, 8'h19, 8'h30, 8'hB3, 8'h48, 8'hA5, 8'hB5, 8'hD1,
    8'hD7, 8'h5E, 8'h92, 8'h2A, 8'hAC, 8'h56, 8'hAA, 8'hC6,
    8'h4F, 8'hB8, 8'h38, 8'hD2, 8'h96, 8'hA4, 8'h7D, 8'hB6,
    8'h76, 8'hFC, 8'h6B, 8'hE2, 8'h9C, 8'h74, 8'h04, 8'hF1,
    8'h45, 8'h9D, 8'h70, 8'h59, 8'h64, 8'h71, 8'h87, 8'h20,
    8'h86, 8'h5B, 8'hCF, 8'h65, 8'hE6, 8'h2D, 8'hA8, 8'h02,
    8'h1B, 8'h60, 8'h25, 8'hAD, 8'hAE, 8'hB0, 8'hB9, 8'hF6,
    8'h1C, 8'h46, 8'h61, 8'h69, 8'h34, 8'h40, 8'h7E, 8'h0F,
    8'h55, 8'h47, 8'hA3, 8'h23, 8'hDD, 8'h51, 8'hAF, 8'h3A,
    8'hC3, 8'h5C, 8'hF9, 8'hCE, 8'hBA, 8'hC5, 8'hEA, 8'h26,
    8'h2C, 8'h53, 8'h0D, 8'h6E, 8'h85, 8'h28, 8'h84, 8'h09,
    8'hD3, 8'hDF, 8'hCD, 8'hF4, 8'h41, 8'h81, 8'h4D, 8'h52,
    8'h6A, 8'hDC, 8'h37, 8'hC8, 8'h6C, 8'hC1, 8'hAB, 8'hFA,
    8'h24, 8'hE1, 8'h7B, 8'h08, 8'h0C, 8'hBD, 8'hB1, 8'h4A,
    8'h78, 8'h88, 8'h95, 8'h8B, 8'hE3, 8'h63, 8'hE8, 8'h6D,
    8'hE9, 8'hCB, 8'hD5, 8'hFE, 8'h3B, 8'h00, 8'h1D, 8'h39,
    8'hF2, 8'hEF, 8'hB7, 8'h0E, 8'h66, 8'h58, 8'hD0, 8'hE4,
    8'hA6, 8'h77, 8'h72, 8'hF8, 8'hEB, 8'h75, 8'h4B, 8'h0A,
    8'h31, 8'h44, 8'h50, 8'hB4, 8'h8F, 8'hED, 8'h1F, 8'h1A,
    8'hDB, 8'h99, 8'h8D, 8'h33, 8'h9F, 8'h11, 8'h83, 8'h14
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_MSG,
    ST_MIX_MSG,
    ST_PAD,
    ST_LOAD_PAD,
    ST_MIX_PAD,
    ST_LOAD_CS,
    ST_MIX_CS,
    ST_EMIT
  } md2_state_t;

  typedef struct packed {
    logic               shift_in;    // shift a byte into the block buffer
    logic               pad_sel;     // shifted byte is the pad value
    logic               pad_latch;   // capture pad length from the next fill
    logic               load;        // load the mixing array
    logic               load_cs;     // load from the checksum, not the buffer
    logic               mix;         // one mixing step
    logic               round_end;   // last step of a round
    logic [ROUND_W-1:0] round_idx;   // round number added at round end
    logic               cs_upd;      // one checksum step
    logic               emit_shift;  // advance to the next digest byte
    logic               clear;       // back to the all-zero start state
  } md2_cmd_t;

  typedef struct packed {
    logic fill_full;                 // fifteen bytes held, next one completes
  } md2_stat_t;

endpackage

### rtl/md2_message_digest_unit.sv
`timescale 1ns / 1ps
// Top level of the MD2 message digest unit: controller plus datapath.
// Depends on md2_pkg, md2_ctrl and md2_datapath.
//
// Usage
//   Input channel (in_valid / in_stall): each beat carries an optional
//   message byte (in_data_byte, taken when in_byte_valid is high) and an
//   optional end-of-message mark (in_finish). A byte and a finish in one
//   beat absorb the byte first, then close the message.
//   Output channel (out_valid / out_stall): after a finish, sixteen beats
//   carry the digest, byte 0 first; out_digest_last marks the sixteenth.
//   The unit then returns to the all-zero start state for a new message.
// Stalls and block processing
//   A beat that does not complete a block is taken without a stall. A beat that
//   completes a 16-byte block stalls the input for a load and a transform: the
//   48-byte mixing array runs 18 rounds at one S-box lookup per cycle, and
//   this serial loop sets the rate. A finish adds pad bytes up to the block
//   end, two loads and two transforms (padded block, then checksum), plus one
//   more block transform when the finishing beat itself fills a block; then
//   the digest beats.
// Reset and flow control
//   rst_n (synchronous, active low) clears chain state, checksum and fill
//   count. The input side is stalled whenever the unit is not idle: through
//   loads, transforms, padding and digest beats; a stalled digest beat holds.
module md2_message_digest_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_valid,
  input  logic       in_finish,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_digest_byte,
  output logic       out_digest_last
);
  import md2_pkg::*;

  md2_cmd_t  cmd;    // controller to datapath
  md2_stat_t stat;   // datapath to controller

  // Sequence block fills, transforms and digest beats
  md2_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_byte_valid   (in_byte_valid),
    .in_finish       (in_finish),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_last (out_digest_last),
    .stat            (stat),
    .cmd             (cmd)
  );

  // Hold the message block, mixing array and checksum; the digest byte
  // comes straight from the head of the mixing array register.
  md2_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_data_byte),
    .stat        (stat),
    .digest_byte (out_digest_byte)
  );

endmodule

### rtl/md2_datapath.sv
`timescale 1ns / 1ps
// Datapath of the MD2 digest unit: block buffer, rotating 48-byte mixing array,
// rotating checksum and fill count. Depends on md2_pkg.
module md2_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  md2_pkg::md2_cmd_t cmd,
  input  logic [7:0]        data_byte,
  output md2_pkg::md2_stat_t stat,
  output logic [7:0]        digest_byte
);
  import md2_pkg::*;

  logic [7:0]        work_r [WORK_BYTES];
  logic [7:0]        work_nxt [WORK_BYTES];
  logic [7:0]        blk_r [BLK_BYTES];
  logic [7:0]        blk_nxt [BLK_BYTES];
  logic [7:0]        cs_r [BLK_BYTES];
  logic [7:0]        cs_nxt [BLK_BYTES];
  logic [7:0]        load_src [BLK_BYTES];
  logic [7:0]        acc_r, acc_nxt;
  logic [7:0]        cacc_r, cacc_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [PAD_W-1:0]  pad_r, pad_nxt;
  logic [7:0]        in_byte;
  logic [7:0]        mix_byte;
  logic [7:0]        cs_byte;

  // Array rotates one byte per step, so position BLK_BYTES holds the
  // untouched block byte i during the first sixteen steps of round zero.
  always_comb begin
    in_byte  = cmd.pad_sel ? 8'(pad_r) : data_byte;
    mix_byte = work_r[0] ^ SBOX[acc_r];
    cs_byte  = cs_r[0] ^ SBOX[work_r[BLK_BYTES] ^ cacc_r];
    for (int i = 0; i < BLK_BYTES; i++) begin
      load_src[i] = cmd.load_cs ? cs_r[i] : blk_r[i];
    end

    work_nxt = work_r;
    blk_nxt  = blk_r;
    cs_nxt   = cs_r;
    acc_nxt  = acc_r;
    cacc_nxt = cacc_r;
    fill_nxt = fill_r;
    pad_nxt  = pad_r;

    if (cmd.shift_in) begin
      for (int i = 0; i < BLK_BYTES - 1; i++) begin
        blk_nxt[i] = blk_r[i + 1];
      end
      blk_nxt[BLK_BYTES-1] = in_byte;
      fill_nxt = fill_r + 1'b1;
    end
    if (cmd.pad_latch) begin
      pad_nxt = PAD_W'(BLK_BYTES) - {1'b0, fill_nxt};
    end

    if (cmd.load) begin
      for (int i = 0; i < BLK_BYTES; i++) begin
        work_nxt[BLK_BYTES + i]     = load_src[i];
        work_nxt[2 * BLK_BYTES + i] = work_r[i] ^ load_src[i];
      end
      acc_nxt  = 8'h00;
      cacc_nxt = cs_r[BLK_BYTES-1];
    end

    if (cmd.mix || cmd.emit_shift) begin
      for (int i = 0; i < WORK_BYTES - 1; i++) begin
        work_nxt[i] = work_r[i + 1];
      end
      work_nxt[WORK_BYTES-1] = cmd.mix ? mix_byte : work_r[0];
    end
    if (cmd.mix) begin
      acc_nxt = cmd.round_end ? mix_byte + 8'(cmd.round_idx) : mix_byte;
    end

    if (cmd.cs_upd) begin
      for (int i = 0; i < BLK_BYTES - 1; i++) begin
        cs_nxt[i] = cs_r[i + 1];
      end
      cs_nxt[BLK_BYTES-1] = cs_byte;
      cacc_nxt = cs_byte;
    end

    if (cmd.clear) begin
      for (int i = 0; i < WORK_BYTES; i++) begin
        work_nxt[i] = 8'h00;
      end
      for (int i = 0; i < BLK_BYTES; i++) begin
        cs_nxt[i] = 8'h00;
      end
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORK_BYTES; i++) begin
        work_r[i] <= 8'h00;
      end
      for (int i = 0; i < BLK_BYTES; i++) begin
        cs_r[i] <= 8'h00;
      end
      fill_r <= '0;
    end else begin
      work_r <= work_nxt;
      cs_r   <= cs_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    acc_r  <= acc_nxt;
    cacc_r <= cacc_nxt;
    pad_r  <= pad_nxt;
  end

  assign stat.fill_full = (fill_r == BYTE_LAST);
  assign digest_byte    = work_r[0];

  // A block is loaded only once the buffer has wrapped back to empty.
  a_load_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> fill_r == '0)
    else $error("mixing array loaded with a partly filled buffer");

  // Filling and mixing never overlap.
  a_no_fill_in_mix: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mix |-> !cmd.shift_in && !cmd.load)
    else $error("buffer or array load during a mixing step");

endmodule

### rtl/md2_ctrl.sv
`timescale 1ns / 1ps
// Controller of the MD2 digest unit: state machine, step and round counters,
// digest beat counter and both channel handshakes. Depends on md2_pkg.
module md2_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_byte_valid,
  input  logic               in_finish,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_digest_last,
  input  md2_pkg::md2_stat_t stat,
  output md2_pkg::md2_cmd_t  cmd
);
  import md2_pkg::*;

  md2_state_t         state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [FILL_W-1:0]  emit_r, emit_nxt;
  logic               fin_pend_r, fin_pend_nxt;
  logic               in_acc;
  logic               out_acc;
  logic               mix_last;
  logic               emit_last;
  logic               mixing;

  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign out_acc   = out_valid && !out_stall;
  assign mix_last  = (step_r == STEP_LAST) && (round_r == ROUND_LAST);
  assign emit_last = (emit_r == BYTE_LAST);
  assign mixing    = (state_r == ST_MIX_MSG) || (state_r == ST_MIX_PAD) ||
                     (state_r == ST_MIX_CS);

  // Next state
  always_comb begin
    state_nxt    = state_r;
    fin_pend_nxt = fin_pend_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_byte_valid && stat.fill_full) begin
            state_nxt    = ST_LOAD_MSG;
            fin_pend_nxt = in_finish;
          end else if (in_finish) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_LOAD_MSG: state_nxt = ST_MIX_MSG;
      ST_MIX_MSG: begin
        if (mix_last) begin
          state_nxt    = fin_pend_r ? ST_PAD : ST_IDLE;
          fin_pend_nxt = 1'b0;
        end
      end
      ST_PAD: begin
        if (stat.fill_full) begin
          state_nxt = ST_LOAD_PAD;
        end
      end
      ST_LOAD_PAD: state_nxt = ST_MIX_PAD;
      ST_MIX_PAD: begin
        if (mix_last) begin
          state_nxt = ST_LOAD_CS;
        end
      end
      ST_LOAD_CS: state_nxt = ST_MIX_CS;
      ST_MIX_CS: begin
        if (mix_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Step, round and beat counters
  always_comb begin
    step_nxt  = '0;
    round_nxt = '0;
    emit_nxt  = '0;
    if (mixing) begin
      step_nxt  = (step_r == STEP_LAST) ? '0 : step_r + 1'b1;
      round_nxt = (step_r == STEP_LAST) ? round_r + 1'b1 : round_r;
    end
    if (state_r == ST_EMIT) begin
      emit_nxt = out_acc ? emit_r + 1'b1 : emit_r;
    end
  end

  // Outputs
  always_comb begin
    cmd             = '0;
    in_stall        = 1'b1;
    out_valid       = 1'b0;
    out_digest_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.shift_in  = in_acc && in_byte_valid;
        cmd.pad_latch = in_acc && in_finish && !(in_byte_valid && stat.fill_full);
      end
      ST_LOAD_MSG, ST_LOAD_PAD: begin
        cmd.load = 1'b1;
      end
      ST_LOAD_CS: begin
        cmd.load    = 1'b1;
        cmd.load_cs = 1'b1;
      end
      ST_MIX_MSG, ST_MIX_PAD, ST_MIX_CS: begin
        cmd.mix       = 1'b1;
        cmd.round_end = (step_r == STEP_LAST);
        cmd.round_idx = round_r;
        cmd.cs_upd    = (state_r != ST_MIX_CS) && (round_r == '0) &&
                        (step_r < STEP_W'(BLK_BYTES));
        cmd.pad_latch = (state_r == ST_MIX_MSG) && mix_last && fin_pend_r;
      end
      ST_PAD: begin
        cmd.shift_in = 1'b1;
        cmd.pad_sel  = 1'b1;
      end
      ST_EMIT: begin
        out_valid       = 1'b1;
        out_digest_last = emit_last;
        cmd.emit_shift  = out_acc;
        cmd.clear       = out_acc && emit_last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= '0;
      round_r    <= '0;
      emit_r     <= '0;
      fin_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      round_r    <= round_nxt;
      emit_r     <= emit_nxt;
      fin_pend_r <= fin_pend_nxt;
    end
  end

  // Digest beats start only after the checksum block has been mixed.
  a_emit_after_cs: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_EMIT) |-> $past(state_r == ST_MIX_CS))
    else $error("digest output started without the checksum transform");

  // The last digest beat frees the input side on the next cycle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_digest_last |=> !in_stall && !out_valid)
    else $error("block not idle after the final digest beat");

  // Input and output sides are never open together.
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall))
    else $error("input accepted while a digest is being delivered");

endmodule
